/* rtl/gkf_pkg.sv */
// ----------------------------------------------------------------------------
// gkf_pkg
// Shared types, register file map and microcode for the yaw Kalman filter.
// ----------------------------------------------------------------------------
package gkf_pkg;

    // multiplier digit width (one digit of the second operand per cycle)
    localparam int DIG_W    = 16;
    localparam int NUM_REGS = 23;
    localparam int RID_W    = 5;
    localparam int PC_W     = 6;
    localparam int LAST_PC  = 42;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_MUL  = 3'd1,
        OP_DIV  = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4,
        OP_WRAP = 3'd5
    } op_t;

    // register file map; filter state sits at the bottom for the reset pass
    typedef enum logic [RID_W-1:0] {
        R_A    = 5'd0,
        R_V    = 5'd1,
        R_P11  = 5'd2,
        R_P12  = 5'd3,
        R_P21  = 5'd4,
        R_P22  = 5'd5,
        R_T    = 5'd6,
        R_Q    = 5'd7,
        R_R    = 5'd8,
        R_G    = 5'd9,
        R_T2   = 5'd10,
        R_QT2  = 5'd11,
        R_QT3  = 5'd12,
        R_QT4  = 5'd13,
        R_XA   = 5'd14,
        R_E    = 5'd15,
        R_TP22 = 5'd16,
        R_N11  = 5'd17,
        R_N12  = 5'd18,
        R_N21  = 5'd19,
        R_N22  = 5'd20,
        R_S    = 5'd21,
        R_TMP  = 5'd22
    } rid_t;

    localparam int NUM_STATE_REGS = 6;

    typedef enum logic [1:0] {
        CFG_PNV  = 2'd0,
        CFG_MNV  = 2'd1,
        CFG_STEP = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT  = 3'd0,
        ST_IDLE  = 3'd1,
        ST_ISSUE = 3'd2,
        ST_EXEC  = 3'd3,
        ST_OUT   = 3'd4
    } state_t;

    // one micro-operation: dst = a op (b >>> sh)
    typedef struct packed {
        op_t        op;
        rid_t       dst;
        rid_t       a;
        rid_t       b;
        logic [1:0] sh;
    } uop_t;

    function automatic uop_t mk(input op_t op, input rid_t d, input rid_t a,
                                input rid_t b, input logic [1:0] sh);
        uop_t u;
        u.op  = op;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        u.sh  = sh;
        return u;
    endfunction

    // microcode for one filter update
    function automatic uop_t uop_fetch(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // operand loads
            6'd0:  u = mk(OP_LOAD, R_T,    R_T,    R_T,    2'd0);
            6'd1:  u = mk(OP_LOAD, R_Q,    R_Q,    R_Q,    2'd0);
            6'd2:  u = mk(OP_LOAD, R_R,    R_R,    R_R,    2'd0);
            6'd3:  u = mk(OP_LOAD, R_G,    R_G,    R_G,    2'd0);
            // noise terms
            6'd4:  u = mk(OP_MUL,  R_T2,   R_T,    R_T,    2'd0);
            6'd5:  u = mk(OP_MUL,  R_QT2,  R_Q,    R_T2,   2'd0);
            6'd6:  u = mk(OP_MUL,  R_QT3,  R_QT2,  R_T,    2'd0);
            6'd7:  u = mk(OP_MUL,  R_QT4,  R_QT2,  R_T2,   2'd0);
            // state prediction and innovation
            6'd8:  u = mk(OP_MUL,  R_TMP,  R_V,    R_T,    2'd0);
            6'd9:  u = mk(OP_ADD,  R_XA,   R_A,    R_TMP,  2'd0);
            6'd10: u = mk(OP_SUB,  R_E,    R_G,    R_V,    2'd0);
            // covariance prediction
            6'd11: u = mk(OP_MUL,  R_TP22, R_T,    R_P22,  2'd0);
            6'd12: u = mk(OP_MUL,  R_TMP,  R_T,    R_P21,  2'd0);
            6'd13: u = mk(OP_ADD,  R_N11,  R_P11,  R_TMP,  2'd0);
            6'd14: u = mk(OP_ADD,  R_N11,  R_N11,  R_QT4,  2'd2);
            6'd15: u = mk(OP_ADD,  R_TMP,  R_P12,  R_TP22, 2'd0);
            6'd16: u = mk(OP_MUL,  R_TMP,  R_T,    R_TMP,  2'd0);
            6'd17: u = mk(OP_ADD,  R_N11,  R_N11,  R_TMP,  2'd0);
            6'd18: u = mk(OP_ADD,  R_N12,  R_P12,  R_TP22, 2'd0);
            6'd19: u = mk(OP_ADD,  R_N12,  R_N12,  R_QT3,  2'd1);
            6'd20: u = mk(OP_ADD,  R_N21,  R_P21,  R_TP22, 2'd0);
            6'd21: u = mk(OP_ADD,  R_N21,  R_N21,  R_QT3,  2'd1);
            6'd22: u = mk(OP_ADD,  R_N22,  R_P22,  R_QT2,  2'd0);
            6'd23: u = mk(OP_ADD,  R_S,    R_R,    R_N22,  2'd0);
            // correction
            6'd24: u = mk(OP_MUL,  R_TMP,  R_N12,  R_E,    2'd0);
            6'd25: u = mk(OP_DIV,  R_TMP,  R_TMP,  R_S,    2'd0);
            6'd26: u = mk(OP_ADD,  R_A,    R_XA,   R_TMP,  2'd0);
            6'd27: u = mk(OP_MUL,  R_TMP,  R_N22,  R_E,    2'd0);
            6'd28: u = mk(OP_DIV,  R_TMP,  R_TMP,  R_S,    2'd0);
            6'd29: u = mk(OP_ADD,  R_V,    R_V,    R_TMP,  2'd0);
            6'd30: u = mk(OP_MUL,  R_TMP,  R_N12,  R_N21,  2'd0);
            6'd31: u = mk(OP_DIV,  R_TMP,  R_TMP,  R_S,    2'd0);
            6'd32: u = mk(OP_SUB,  R_P11,  R_N11,  R_TMP,  2'd0);
            6'd33: u = mk(OP_MUL,  R_TMP,  R_N12,  R_N22,  2'd0);
            6'd34: u = mk(OP_DIV,  R_TMP,  R_TMP,  R_S,    2'd0);
            6'd35: u = mk(OP_SUB,  R_P12,  R_N12,  R_TMP,  2'd0);
            6'd36: u = mk(OP_MUL,  R_TMP,  R_N21,  R_N22,  2'd0);
            6'd37: u = mk(OP_DIV,  R_TMP,  R_TMP,  R_S,    2'd0);
            6'd38: u = mk(OP_SUB,  R_P21,  R_N21,  R_TMP,  2'd0);
            6'd39: u = mk(OP_MUL,  R_TMP,  R_N22,  R_N22,  2'd0);
            6'd40: u = mk(OP_DIV,  R_TMP,  R_TMP,  R_S,    2'd0);
            6'd41: u = mk(OP_SUB,  R_P22,  R_N22,  R_TMP,  2'd0);
            // angle wrap and result capture
            default: u = mk(OP_WRAP, R_A,  R_A,    R_V,    2'd0);
        endcase
        return u;
    endfunction

endpackage

/* rtl/gkf_if.sv */
// ----------------------------------------------------------------------------
// gkf_if
// Valid/ready channels for gyro samples and filter results.
// ----------------------------------------------------------------------------
interface gkf_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gyro_rate;

    modport source (output valid, output gyro_rate, input ready);
    modport sink   (input valid, input gyro_rate, output ready);
endinterface

interface gkf_res_if #(parameter int SW = 48);
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] rate_estimate;
    logic signed [SW-1:0] angle_estimate;
    logic                 angle_was_reset;

    modport source (output valid, output rate_estimate, output angle_estimate,
                    output angle_was_reset, input ready);
    modport sink   (input valid, input rate_estimate, input angle_estimate,
                    input angle_was_reset, output ready);
endinterface

/* rtl/gkf_ram.sv */
// ----------------------------------------------------------------------------
// gkf_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gkf_ram #(
    parameter int W = 48,
    parameter int D = 23
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr_a,
    input  logic [$clog2(D)-1:0] raddr_b,
    output logic [W-1:0]         rdata_a,
    output logic [W-1:0]         rdata_b
);
    logic [W-1:0] mem [D];

    // write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

/* rtl/gyro_yaw_kalman_filter_top.sv */
// ----------------------------------------------------------------------------
// gyro_yaw_kalman_filter_top
// Two-state yaw Kalman filter, microcoded over one shared mul/div/add unit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  smp     | in  | valid/ready        | gyro_rate
//  res     | out | valid/ready        | rate_estimate, angle_estimate, angle_was_reset
//  apb     | in  | psel/penable/pready| paddr, pwdata, prdata
//
//  the shared unit divides one quotient bit per cycle and multiplies in
//  16-bit digits, ND = ceil(STATE_WIDTH/16) digits per operand
//  after reset an init pass loads the filter state; smp.ready stays low
//  a finished result waits in the output register; the next sample is taken
//  once that register is free or being emptied
module gyro_yaw_kalman_filter_top #(
    parameter int FRAC_BITS   = 16,
    parameter int STATE_WIDTH = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    gkf_smp_if.sink     smp,
    gkf_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gkf_pkg::*;

    localparam int SW    = STATE_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int ND    = (SW + DIG_W - 1) / DIG_W;
    localparam int PW    = DIG_W * ND + SW;
    localparam int MW    = PW + 1;
    localparam int DW    = SW + FB;
    localparam int XW    = SW + 42;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int UP    = (FB > 16) ? FB - 16 : 0;
    localparam int DN    = (FB < 16) ? 16 - FB : 0;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [MW-1:0]        MAXM = MW'(SMAX);
    localparam logic [MW-1:0]        HALF = MW'(1) << (FB - 1);
    localparam logic signed [SW-1:0] ONE  = SW'(1) << FB;
    localparam logic signed [SW-1:0] P22R = SW'((9 * (64'd1 << FB) + 5) / 10);
    localparam logic signed [XW-1:0] LIM  = XW'(360) << FB;

    // saturate a wide signed value to the state range
    function automatic logic signed [SW-1:0] sat_x(input logic signed [XW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > XW'(SMAX))
            r = SMAX;
        else if (v < XW'(SMIN))
            r = SMIN;
        else
            r = v[SW-1:0];
        return r;
    endfunction

    // signed result from magnitude with saturation
    function automatic logic signed [SW-1:0] from_mag(input logic neg,
                                                      input logic [MW-1:0] m);
        logic signed [SW-1:0] r;
        if (neg)
            r = (m > MAXM + MW'(1)) ? SMIN : -$signed(m[SW-1:0]);
        else
            r = (m > MAXM) ? SMAX : $signed(m[SW-1:0]);
        return r;
    endfunction

    // unsigned Q16.16 register to internal format
    function automatic logic signed [SW-1:0] from_q16(input logic [31:0] v);
        logic [XW-1:0] w;
        w = (XW'(v) << UP) >> DN;
        return sat_x($signed(w));
    endfunction

    // configuration registers
    logic [31:0] pnv_reg;
    logic [31:0] mnv_reg;
    logic [15:0] st_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pnv_reg <= 32'd4734976;
            mnv_reg <= 32'd65536;
            st_reg  <= 16'd1311;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(paddr[3:2]))
                CFG_PNV:  pnv_reg <= pwdata;
                CFG_MNV:  mnv_reg <= pwdata;
                CFG_STEP: st_reg  <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_idx_t'(paddr[3:2]))
            CFG_PNV:  prdata = pnv_reg;
            CFG_MNV:  prdata = mnv_reg;
            CFG_STEP: prdata = {16'd0, st_reg};
            default:  prdata = 32'd0;
        endcase
    end

    // sequencer and datapath registers
    state_t                  state_reg, state_next;
    logic [PC_W-1:0]         pc_reg, pc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [2:0]              init_reg, init_next;
    logic                    ovalid_reg, ovalid_next;
    logic signed [15:0]      gyro_reg, gyro_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [SW-1:0]           rem_reg, rem_next;
    logic [DW-1:0]           quo_reg, quo_next;
    logic signed [SW-1:0]    orate_reg, orate_next;
    logic signed [SW-1:0]    oangle_reg, oangle_next;
    logic                    oflag_reg, oflag_next;

    // register file
    uop_t                    uop;
    logic                    rf_we;
    logic [RID_W-1:0]        rf_waddr;
    logic signed [SW-1:0]    rf_wdata;
    logic [SW-1:0]           rd_a, rd_b;

    assign uop = uop_fetch(pc_reg);

    gkf_ram #(.W(SW), .D(NUM_REGS)) u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (uop.a),
        .raddr_b (uop.b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // operand views for the shared unit
    logic signed [SW-1:0]  opa, opb, opb_sh;
    logic                  a_neg, b_neg;
    logic [SW-1:0]         mag_a, mag_b;
    logic [DIG_W*ND-1:0]   mb_sh;
    logic [DW-1:0]         dvd_sh;
    logic [SW:0]           trial;
    logic [MW-1:0]         mul_m;
    logic [MW-1:0]         quo_r;
    logic signed [SW:0]    sum;
    logic signed [XW-1:0]  ang_x;
    logic                  wrap;
    logic                  smp_fire;

    always_comb
    begin
        opa    = $signed(rd_a);
        opb    = $signed(rd_b);
        opb_sh = opb >>> uop.sh;
        a_neg  = opa[SW-1];
        b_neg  = opb[SW-1];
        mag_a  = a_neg ? SW'(-opa) : SW'(opa);
        mag_b  = b_neg ? SW'(-opb) : SW'(opb);
        mb_sh  = (DIG_W*ND)'(mag_b) << (DIG_W * cnt_reg);
        dvd_sh = {mag_a, {FB{1'b0}}} << cnt_reg;
        trial  = {rem_reg, dvd_sh[DW-1]};
        mul_m  = (MW'(prod_reg) + HALF) >> FB;
        quo_r  = MW'(quo_reg) + MW'(rem_reg >= (mag_b - rem_reg));
        sum    = (uop.op == OP_SUB) ? ((SW+1)'(opa) - (SW+1)'(opb_sh))
                                    : ((SW+1)'(opa) + (SW+1)'(opb_sh));
        ang_x  = XW'(opa);
        wrap   = (ang_x >= LIM) || (ang_x <= -LIM);
    end

    assign smp_fire  = smp.valid && smp.ready;
    assign smp.ready = (state_reg == ST_IDLE) && (!ovalid_reg || res.ready);

    // next state, sequencing and shared unit
    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        cnt_next    = cnt_reg;
        init_next   = init_reg;
        ovalid_next = ovalid_reg;
        gyro_next   = gyro_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        orate_next  = orate_reg;
        oangle_next = oangle_reg;
        oflag_next  = oflag_reg;
        rf_we       = 1'b0;
        rf_waddr    = uop.dst;
        rf_wdata    = '0;

        if (ovalid_reg && res.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                // load reset values of the filter state
                rf_we    = 1'b1;
                rf_waddr = RID_W'(init_reg);
                unique case (rid_t'(RID_W'(init_reg)))
                    R_P11:   rf_wdata = ONE;
                    R_P22:   rf_wdata = P22R;
                    default: rf_wdata = '0;
                endcase
                init_next = init_reg + 3'd1;
                if (init_reg == 3'(NUM_STATE_REGS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (smp_fire)
                begin
                    gyro_next  = smp.gyro_rate;
                    pc_next    = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                // operand read in flight
                cnt_next   = '0;
                prod_next  = '0;
                rem_next   = '0;
                quo_next   = '0;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (uop.op)
                    OP_LOAD:
                    begin
                        rf_we = 1'b1;
                        unique case (uop.dst)
                            R_T:     rf_wdata = from_q16({16'd0, st_reg});
                            R_Q:     rf_wdata = from_q16(pnv_reg);
                            R_R:     rf_wdata = from_q16(mnv_reg);
                            default: rf_wdata = sat_x(XW'(gyro_reg) <<< FB);
                        endcase
                    end
                    OP_MUL:
                    begin
                        if (cnt_reg == CNT_W'(ND))
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = from_mag(a_neg != b_neg, mul_m);
                        end
                        else
                        begin
                            prod_next = (prod_reg << DIG_W)
                                      + (PW'(mag_a)
                                         * PW'(mb_sh[DIG_W*ND-1 -: DIG_W]));
                            cnt_next  = cnt_reg + CNT_W'(1);
                        end
                    end
                    OP_DIV:
                    begin
                        if (cnt_reg == CNT_W'(DW))
                        begin
                            rf_we = 1'b1;
                            if (mag_b == '0)
                                rf_wdata = a_neg ? SMIN : SMAX;
                            else
                                rf_wdata = from_mag(a_neg != b_neg, quo_r);
                        end
                        else
                        begin
                            // restoring step, one quotient bit
                            if (trial >= (SW+1)'(mag_b))
                            begin
                                rem_next = SW'(trial - (SW+1)'(mag_b));
                                quo_next = {quo_reg[DW-2:0], 1'b1};
                            end
                            else
                            begin
                                rem_next = trial[SW-1:0];
                                quo_next = {quo_reg[DW-2:0], 1'b0};
                            end
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    OP_ADD, OP_SUB:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = sat_x(XW'(sum));
                    end
                    OP_WRAP:
                    begin
                        rf_we       = 1'b1;
                        rf_wdata    = wrap ? '0 : opa;
                        orate_next  = opb;
                        oangle_next = wrap ? '0 : opa;
                        oflag_next  = wrap;
                    end
                    default: ;
                endcase

                if (rf_we)
                begin
                    if (uop.op == OP_WRAP)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT:
            begin
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            pc_reg     <= '0;
            cnt_reg    <= '0;
            init_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            cnt_reg    <= cnt_next;
            init_reg   <= init_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        gyro_reg   <= gyro_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        orate_reg  <= orate_next;
        oangle_reg <= oangle_next;
        oflag_reg  <= oflag_next;
    end

    assign res.valid           = ovalid_reg;
    assign res.rate_estimate   = orate_reg;
    assign res.angle_estimate  = oangle_reg;
    assign res.angle_was_reset = oflag_reg;

    // checks
    a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
        smp_fire |=> state_reg == ST_ISSUE)
        else $error("sample accepted without starting an update");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.angle_was_reset |-> res.angle_estimate == '0)
        else $error("wrapped angle not zeroed");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |-> pc_reg <= PC_W'(LAST_PC))
        else $error("microcode counter out of range");

    a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && uop.op == OP_MUL |-> cnt_reg <= CNT_W'(ND))
        else $error("multiplier digit counter overrun");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside result stage");
endmodule
